### rtl/sia_pkg.sv
`default_nettype none

package sia_pkg;

  // Build-time defaults
  localparam int SIA_CAPACITY   = 16;
  localparam int SIA_ITEM_WIDTH = 32;

  // Transaction field widths
  localparam int REQ_W    = 2;
  localparam int ITEM_W   = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 5;

  // Config port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int LIMIT_W = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  // Register index decoded from paddr[2]
  typedef enum logic {
    REG_CAP_LIMIT = 1'b0
  } reg_idx_e;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_GET    = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_e;

endpackage

`default_nettype wire

### rtl/sia_if.sv
`default_nettype none

// Request channel
interface sia_req_if;
  logic                       valid;
  logic                       ready;
  logic [sia_pkg::REQ_W-1:0]  req_type;
  logic [sia_pkg::ITEM_W-1:0] item_value;
  logic [sia_pkg::POS_W-1:0]  position;

  modport source (output valid, output req_type, output item_value, output position,
                  input ready);
  modport sink   (input valid, input req_type, input item_value, input position,
                  output ready);
endinterface

// Response channel
interface sia_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sia_pkg::ITEM_W-1:0]   read_value;
  logic [sia_pkg::STATUS_W-1:0] status;
  logic [sia_pkg::FILL_W-1:0]   fill_level;

  modport source (output valid, output read_value, output status, output fill_level,
                  input ready);
  modport sink   (input valid, input read_value, input status, input fill_level,
                  output ready);
endinterface

`default_nettype wire

### rtl/sorted_insert_array_top.sv
`default_nettype none

// Sorted insert array: keeps up to CAPACITY unsigned entries in ascending
// order in a chain of cells, one entry per cell. Each request transaction is
// insert (the new item lands ahead of any equal entries, later entries shift
// up), get by index, or remove by index (later entries shift down). Every
// request yields exactly one response transaction with status (ok, full,
// index out of range), read value (nonzero only for a good get) and the fill
// level after the request. Rate: one request per clock unless the response
// side stalls; the response appears in the output register in the cycle
// after acceptance and a new request is taken in the same cycle as the
// previous response leaves. The cycle time is set by the per-cell compare
// against the incoming item plus the neighbor-select mux in each cell; all
// cells shift together on the same edge. capacity_limit (APB offset 0x0,
// reset 16) caps the fill level; 0 acts as 1 and values above CAPACITY act
// as CAPACITY. Lowering it below the current fill keeps the stored entries.
// No clearing pass: empty cells are tracked by the fill count alone.
module sorted_insert_array_top #(
  parameter int CAPACITY   = sia_pkg::SIA_CAPACITY,
  parameter int ITEM_WIDTH = sia_pkg::SIA_ITEM_WIDTH
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  sia_req_if.sink                      req_i,
  sia_rsp_if.source                    rsp_o,
  // APB config port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [sia_pkg::PADDR_W-1:0]   paddr,
  input  wire [sia_pkg::PDATA_W-1:0]   pwdata,
  output logic [sia_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int CntW = $clog2(CAPACITY+1);
  localparam int IdxW = $clog2(CAPACITY);
  localparam int CmpW = (CntW > sia_pkg::LIMIT_W) ? CntW : sia_pkg::LIMIT_W;

  // ---------------------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------------------
  logic [sia_pkg::LIMIT_W-1:0] limit_q;
  logic                        cfg_wr;
  logic                        cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = sia_pkg::reg_idx_e'(paddr[2]) == sia_pkg::REG_CAP_LIMIT;
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? sia_pkg::PDATA_W'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= sia_pkg::LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_q <= pwdata[sia_pkg::LIMIT_W-1:0];
    end
  end

  // effective limit, clamped to 1..CAPACITY
  logic [CmpW-1:0] eff_lim;
  always_comb begin
    eff_lim = CmpW'(limit_q);
    if (eff_lim == '0) begin
      eff_lim = CmpW'(1);
    end else if (eff_lim > CmpW'(CAPACITY)) begin
      eff_lim = CmpW'(CAPACITY);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: output register decouples the two sides
  // ---------------------------------------------------------------------------
  logic rsp_valid_q;
  logic req_acc;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_acc     = req_i.valid && req_i.ready;

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  logic [CntW-1:0]       count_q, count_d;
  logic                  is_full;
  logic                  pos_bad;
  logic [IdxW-1:0]       pos_idx;
  logic [ITEM_WIDTH-1:0] item;
  logic [ITEM_WIDTH-1:0] entry_w [CAPACITY];
  logic                  lt_w    [CAPACITY];
  sia_pkg::cell_op_e     cell_op;
  sia_pkg::status_e      status_d;
  logic [sia_pkg::ITEM_W-1:0] read_d;

  assign item    = ITEM_WIDTH'(req_i.item_value);
  assign pos_idx = IdxW'(req_i.position);
  assign is_full = CmpW'(count_q) >= eff_lim;
  // count never exceeds CAPACITY, so this also covers positions past the chain
  assign pos_bad = CmpW'(req_i.position) >= CmpW'(count_q);

  always_comb begin
    cell_op  = sia_pkg::CELL_HOLD;
    status_d = sia_pkg::ST_OK;
    read_d   = '0;
    count_d  = count_q;
    unique case (sia_pkg::req_e'(req_i.req_type))
      sia_pkg::REQ_INSERT: begin
        if (is_full) begin
          status_d = sia_pkg::ST_FULL;
        end else begin
          cell_op = sia_pkg::CELL_INSERT;
          count_d = count_q + CntW'(1);
        end
      end
      sia_pkg::REQ_GET: begin
        if (pos_bad) begin
          status_d = sia_pkg::ST_RANGE;
        end else begin
          read_d = sia_pkg::ITEM_W'(entry_w[pos_idx]);
        end
      end
      sia_pkg::REQ_REMOVE: begin
        if (pos_bad) begin
          status_d = sia_pkg::ST_RANGE;
        end else begin
          cell_op = sia_pkg::CELL_REMOVE;
          count_d = count_q - CntW'(1);
        end
      end
      default: begin
        // unknown request: no change, status ok
      end
    endcase
    if (!req_acc) begin
      cell_op = sia_pkg::CELL_HOLD;
    end
  end

  // ---------------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ITEM_WIDTH-1:0] left_entry;
    logic                  left_lt;
    logic [ITEM_WIDTH-1:0] right_entry;

    if (k == 0) begin : g_head
      assign left_entry = item;
      assign left_lt    = 1'b1;
    end else begin : g_body
      assign left_entry = entry_w[k-1];
      assign left_lt    = lt_w[k-1];
    end

    if (k == CAPACITY-1) begin : g_tail
      assign right_entry = entry_w[k];
    end else begin : g_mid
      assign right_entry = entry_w[k+1];
    end

    sia_cell #(
      .CAPACITY   (CAPACITY),
      .ITEM_WIDTH (ITEM_WIDTH),
      .IDX        (k)
    ) u_cell (
      .clk_i         (clk_i),
      .op_i          (cell_op),
      .item_i        (item),
      .count_i       (count_q),
      .pos_i         (pos_idx),
      .left_entry_i  (left_entry),
      .left_lt_i     (left_lt),
      .right_entry_i (right_entry),
      .entry_o       (entry_w[k]),
      .lt_o          (lt_w[k])
    );
  end

  // ---------------------------------------------------------------------------
  // Fill count and response register
  // ---------------------------------------------------------------------------
  logic [sia_pkg::ITEM_W-1:0]   rsp_read_q;
  logic [sia_pkg::STATUS_W-1:0] rsp_status_q;
  logic [sia_pkg::FILL_W-1:0]   rsp_fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_acc) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      rsp_read_q   <= read_d;
      rsp_status_q <= status_d;
      rsp_fill_q   <= sia_pkg::FILL_W'(count_d);
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.read_value = rsp_read_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.fill_level = rsp_fill_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && cell_op == sia_pkg::CELL_INSERT)
      |=> count_q == CntW'($past(count_q) + CntW'(1)))
    else $error("insert did not grow the fill count");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != sia_pkg::ST_OK) |-> rsp_o.read_value == '0)
    else $error("nonzero read value on failed request");

  for (genvar k = 0; k < CAPACITY-1; k++) begin : g_sorted_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (CntW'(k+2) <= count_q) |-> entry_w[k] <= entry_w[k+1])
      else $error("chain out of order");
  end

endmodule

`default_nettype wire

### rtl/sia_cell.sv
`default_nettype none

// One slot of the sorted chain. Holds a single entry and trades it with its
// neighbors on insert (shift up) and remove (shift down).
module sia_cell #(
  parameter int CAPACITY   = sia_pkg::SIA_CAPACITY,
  parameter int ITEM_WIDTH = sia_pkg::SIA_ITEM_WIDTH,
  parameter int IDX        = 0
) (
  input  wire                                 clk_i,
  input  wire sia_pkg::cell_op_e              op_i,
  input  wire [ITEM_WIDTH-1:0]                item_i,
  input  wire [$clog2(CAPACITY+1)-1:0]        count_i,
  input  wire [$clog2(CAPACITY)-1:0]          pos_i,
  input  wire [ITEM_WIDTH-1:0]                left_entry_i,
  input  wire                                 left_lt_i,
  input  wire [ITEM_WIDTH-1:0]                right_entry_i,
  output logic [ITEM_WIDTH-1:0]               entry_o,
  output logic                                lt_o
);

  localparam int CntW = $clog2(CAPACITY+1);
  localparam int IdxW = $clog2(CAPACITY);

  logic [ITEM_WIDTH-1:0] entry_q, entry_d;
  logic                  occupied;

  assign occupied = CntW'(IDX) < count_i;
  // unoccupied slots count as "not less" so the insert point never passes them
  assign lt_o     = occupied && (entry_q < item_i);
  assign entry_o  = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (op_i)
      sia_pkg::CELL_INSERT: begin
        if (!lt_o) begin
          entry_d = left_lt_i ? item_i : left_entry_i;
        end
      end
      sia_pkg::CELL_REMOVE: begin
        if (IdxW'(IDX) >= pos_i) begin
          entry_d = right_entry_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire
